### src/rfid_ascii_frame_checker_core_defines.svh
// Assertion macros used by the checker file rfac_checker.sv.
`ifndef RFID_ASCII_FRAME_CHECKER_CORE_DEFINES_SVH
`define RFID_ASCII_FRAME_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rfac_pkg.sv
`default_nettype none

package rfac_pkg;

    localparam logic [3:0] FRAME_LAST_POS = 4'd12;  // 13-byte frame
    localparam logic [3:0] ID_FIRST_POS   = 4'd3;
    localparam logic [3:0] CHECK_HI_POS   = 4'd11;
    localparam logic [7:0] MISS_LIMIT_RST = 8'd4;
    localparam logic [7:0] MISS_COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_GOOD = 2'd1,
        EV_BAD  = 2'd2,
        EV_DROP = 2'd3
    } frame_event_t;

    typedef enum logic {
        REQ_BYTE    = 1'b0,
        REQ_TIMEOUT = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [3:0]  pos;
        logic [7:0]  xor_acc;
        logic [3:0]  high_nib;
        logic [31:0] id_acc;
        logic [7:0]  rx_check;
        logic        bad_char;
        logic [7:0]  miss_count;
        logic [31:0] held_id;
        logic        held_present;
    } rfac_state_t;

    // {not_hex, nibble}; nibble is zero for a non-hex character
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] diff;
        logic [4:0] res;
        res = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            diff = c - 8'h30;
            res  = {1'b0, diff[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            diff = c - 8'h37;
            res  = {1'b0, diff[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            diff = c - 8'h57;
            res  = {1'b0, diff[3:0]};
        end else begin
            diff = 8'h00;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/rfac_step.sv
`default_nettype none

module rfac_step import rfac_pkg::*; (
    input  rfac_state_t  cur,
    input  logic         req_type,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   miss_limit,
    output rfac_state_t  nxt,
    output frame_event_t ev
);

    logic [4:0] dec;
    logic [3:0] nib;
    logic [7:0] pair;
    logic [7:0] miss_inc;

    assign dec  = hex_decode(rx_byte);
    assign nib  = dec[3:0];
    assign pair = {cur.high_nib, nib};
    assign miss_inc = (cur.miss_count != MISS_COUNT_MAX) ? cur.miss_count + 8'd1
                                                          : cur.miss_count;

    always_comb begin
        nxt = cur;
        ev  = EV_NONE;
        if (req_type == REQ_BYTE) begin
            nxt.miss_count = 8'd0;
            if (cur.pos != 4'd0) begin
                if (dec[4]) begin
                    nxt.bad_char = 1'b1;
                end
                if (cur.pos >= ID_FIRST_POS && cur.pos < CHECK_HI_POS) begin
                    nxt.id_acc = {cur.id_acc[27:0], nib};
                end
                if (cur.pos[0]) begin
                    nxt.high_nib = nib;
                end else if (cur.pos < CHECK_HI_POS) begin
                    nxt.xor_acc = cur.xor_acc ^ pair;
                end else begin
                    nxt.rx_check = pair;
                end
            end
            if (cur.pos >= FRAME_LAST_POS) begin
                if (!nxt.bad_char && nxt.rx_check == nxt.xor_acc) begin
                    nxt.held_id      = nxt.id_acc;
                    nxt.held_present = 1'b1;
                    ev               = EV_GOOD;
                end else begin
                    ev = EV_BAD;
                end
                nxt.pos      = 4'd0;
                nxt.xor_acc  = 8'd0;
                nxt.high_nib = 4'd0;
                nxt.id_acc   = 32'd0;
                nxt.rx_check = 8'd0;
                nxt.bad_char = 1'b0;
            end else begin
                nxt.pos = cur.pos + 4'd1;
            end
        end else if (cur.pos != 4'd0) begin
            // partial frame dropped at timeout
            nxt.pos        = 4'd0;
            nxt.xor_acc    = 8'd0;
            nxt.high_nib   = 4'd0;
            nxt.id_acc     = 32'd0;
            nxt.rx_check   = 8'd0;
            nxt.bad_char   = 1'b0;
            nxt.miss_count = 8'd0;
            ev             = EV_BAD;
        end else if (miss_inc > miss_limit) begin
            nxt.miss_count   = 8'd0;
            nxt.held_id      = 32'd0;
            nxt.held_present = 1'b0;
            ev               = EV_DROP;
        end else begin
            nxt.miss_count = miss_inc;
        end
    end

endmodule

`default_nettype wire

### src/rfid_ascii_frame_checker_core.sv
// Card reader frame checker.
// Input channel (s_valid/s_ready): one item per UART byte (s_req_type = 0,
// byte on s_rx_byte) or per read timeout (s_req_type = 1).
// Result channel (m_valid/m_ready): exactly one item per input item, in order:
// held card id, presence flag, and event (none, good frame, bad frame, dropped).
// The accept loads the input register, and the frame state update then moves
// the item into the result register. Throughput is one item per cycle while
// the receiver takes results; the only loop is the frame state update.
// When the receiver stalls, the result holds and the input register still
// takes one more item; s_ready drops only when both stages are full.
// cfg_wr_en writes miss_limit from cfg_wr_data; write it only while idle.
// Synchronous active-low reset empties both stages, clears the frame state,
// the held card and the miss count, and sets miss_limit to 4.
`default_nettype none

module rfid_ascii_frame_checker_core import rfac_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_card_id,
    output logic             m_card_present,
    output logic [1:0]       m_frame_event
);

    logic         in_valid_reg;
    logic         in_req_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    logic [31:0]  out_id_reg;
    logic         out_present_reg;
    frame_event_t out_event_reg;
    logic [7:0]   miss_limit_reg;
    rfac_state_t  state_reg;
    rfac_state_t  state_next;
    frame_event_t event_next;
    logic         advance;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    rfac_step u_step (
        .cur        (state_reg),
        .req_type   (in_req_reg),
        .rx_byte    (in_byte_reg),
        .miss_limit (miss_limit_reg),
        .nxt        (state_next),
        .ev         (event_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            miss_limit_reg <= MISS_LIMIT_RST;
            state_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                miss_limit_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg  <= s_req_type;
            in_byte_reg <= s_rx_byte;
        end
        if (in_valid_reg && advance) begin
            out_id_reg      <= state_next.held_id;
            out_present_reg <= state_next.held_present;
            out_event_reg   <= event_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_card_id      = out_id_reg;
    assign m_card_present = out_present_reg;
    assign m_frame_event  = out_event_reg;

endmodule

`default_nettype wire

### src/rfac_checker.sv
`default_nettype none
`include "rfid_ascii_frame_checker_core_defines.svh"

module rfac_checker import rfac_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_card_id,
    input wire logic        m_card_present,
    input wire logic [1:0]  m_frame_event
);

    `RFAC_ASSERT_IMP(a_absent_id_zero, aclk, aresetn,
        m_valid && !m_card_present, m_card_id == 32'd0,
        "card id nonzero while absent")

    `RFAC_ASSERT_IMP(a_good_present, aclk, aresetn,
        m_valid && m_frame_event == EV_GOOD, m_card_present,
        "good frame without card")

    `RFAC_ASSERT_IMP(a_drop_absent, aclk, aresetn,
        m_valid && m_frame_event == EV_DROP, !m_card_present,
        "card still present after drop")

    `RFAC_ASSERT_NXT(a_stall_hold, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_card_id) && $stable(m_card_present) && $stable(m_frame_event),
        "result item changed while stalled")

endmodule

bind rfid_ascii_frame_checker_core rfac_checker u_rfac_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_card_id      (m_card_id),
    .m_card_present (m_card_present),
    .m_frame_event  (m_frame_event)
);

`default_nettype wire

### bench/tb_rfid_ascii_frame_checker_core.sv
`timescale 1ns / 100ps

module tb_rfid_ascii_frame_checker_core;
    import rfac_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [31:0]  id;
        logic         present;
        frame_event_t ev;
    } card_status_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_card_id;
    logic        m_card_present;
    logic [1:0]  m_frame_event;

    // reader state as the block should hold it
    logic [7:0]  miss_limit;
    logic [3:0]  frame_pos;
    logic [7:0]  frame_xor;
    logic [3:0]  frame_hi;
    logic [31:0] frame_id;
    logic [7:0]  frame_chk;
    logic        frame_bad;
    logic [7:0]  miss_cnt;
    logic [31:0] held_id;
    logic        held_present;

    card_status_t card_status_q [$];
    int fail_count = 0;
    int items_sent = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    rfid_ascii_frame_checker_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_card_id      (m_card_id),
        .m_card_present (m_card_present),
        .m_frame_event  (m_frame_event)
    );

    always #5 aclk = ~aclk;

    // {not_hex, nibble}
    function automatic logic [4:0] ascii_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - 8'h30)};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - 8'h37)};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - 8'h57)};
        return 5'h10;
    endfunction

    function automatic void clear_frame();
        frame_pos = '0;
        frame_xor = '0;
        frame_hi  = '0;
        frame_id  = '0;
        frame_chk = '0;
        frame_bad = 1'b0;
    endfunction

    function automatic void reset_reader();
        clear_frame();
        miss_limit   = MISS_LIMIT_RST;
        miss_cnt     = '0;
        held_id      = '0;
        held_present = 1'b0;
    endfunction

    function automatic card_status_t step_card_reader(input req_type_t req,
                                                      input logic [7:0] b);
        card_status_t res;
        logic [4:0]   dec;
        logic [3:0]   nib;
        res.ev = EV_NONE;
        if (req == REQ_BYTE) begin
            miss_cnt = '0;
            if (frame_pos != 0) begin
                dec = ascii_nibble(b);
                if (dec[4]) frame_bad = 1'b1;
                nib = dec[4] ? 4'h0 : dec[3:0];
                if (frame_pos >= ID_FIRST_POS && frame_pos < CHECK_HI_POS)
                    frame_id = {frame_id[27:0], nib};
                if (frame_pos[0])
                    frame_hi = nib;
                else if (frame_pos < CHECK_HI_POS)
                    frame_xor ^= {frame_hi, nib};
                else
                    frame_chk = {frame_hi, nib};
            end
            if (frame_pos >= FRAME_LAST_POS) begin
                if (!frame_bad && frame_chk == frame_xor) begin
                    held_id      = frame_id;
                    held_present = 1'b1;
                    res.ev       = EV_GOOD;
                end else begin
                    res.ev = EV_BAD;
                end
                clear_frame();
            end else begin
                frame_pos = frame_pos + 4'd1;
            end
        end else if (frame_pos != 0) begin
            // partial frame dropped
            clear_frame();
            miss_cnt = '0;
            res.ev   = EV_BAD;
        end else begin
            if (miss_cnt != MISS_COUNT_MAX) miss_cnt = miss_cnt + 8'd1;
            if (miss_cnt > miss_limit) begin
                miss_cnt     = '0;
                held_id      = '0;
                held_present = 1'b0;
                res.ev       = EV_DROP;
            end
        end
        res.id      = held_id;
        res.present = held_present;
        return res;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] edges [6];
        logic [7:0] c;
        logic [4:0] dec;
        edges = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        if ($urandom_range(1)) return edges[$urandom_range(5)];
        do begin
            c   = 8'($urandom_range(255));
            dec = ascii_nibble(c);
        end while (!dec[4]);
        return c;
    endfunction

    // results and receiver stalls
    always @(posedge aclk) begin : result_check
        card_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (card_status_q.size() == 0) begin
                $error("result item with nothing expected");
                fail_count++;
            end else begin
                want = card_status_q.pop_front();
                if (m_card_id !== want.id) begin
                    $error("card_id: expected %h, actual %h", want.id, m_card_id);
                    fail_count++;
                end
                if (m_card_present !== want.present) begin
                    $error("card_present: expected %b, actual %b",
                           want.present, m_card_present);
                    fail_count++;
                end
                if (m_frame_event !== want.ev) begin
                    $error("frame_event: expected %0d, actual %0d",
                           want.ev, m_frame_event);
                    fail_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input req_type_t req, input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_rx_byte  <= b;
        do @(posedge aclk); while (!s_ready);
        card_status_q.push_back(step_card_reader(req, b));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (card_status_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_miss_limit(input logic [7:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        miss_limit = v;
    endtask

    // bad_at: position of a non-hex character, 0 for none
    task automatic send_frame(input logic [31:0] id, input bit corrupt_sum, input int bad_at);
        logic [7:0] data [5];
        logic [7:0] chars [13];
        logic [7:0] sum;
        data[0] = 8'($urandom_range(255));
        data[1] = id[31:24];
        data[2] = id[23:16];
        data[3] = id[15:8];
        data[4] = id[7:0];
        sum = data[0] ^ data[1] ^ data[2] ^ data[3] ^ data[4];
        if (corrupt_sum) sum ^= 8'($urandom_range(255, 1));
        chars[0] = 8'($urandom_range(255));
        for (int k = 0; k < 5; k++) begin
            chars[1 + 2 * k] = hex_char(data[k][7:4]);
            chars[2 + 2 * k] = hex_char(data[k][3:0]);
        end
        chars[11] = hex_char(sum[7:4]);
        chars[12] = hex_char(sum[3:0]);
        if (bad_at != 0) chars[bad_at] = non_hex_char();
        for (int i = 0; i < 13; i++) send_item(REQ_BYTE, chars[i]);
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        stall_pct       = 0;
        send_frame(32'hFFFF_FFFF, 1'b0, 0);
        send_item(REQ_BYTE, 8'h00);
        send_item(REQ_BYTE, "0");
        send_item(REQ_TIMEOUT, 8'hFF);             // partial frame
        repeat (4) send_item(REQ_TIMEOUT, 8'h00);
        send_item(REQ_BYTE, 8'hFF);                // clears miss count, opens a frame
        send_item(REQ_TIMEOUT, 8'h00);
        repeat (5) send_item(REQ_TIMEOUT, 8'h00);  // fifth one drops the card
    endtask

    task automatic test_bad_frames();
        send_frame(32'h0000_0000, 1'b0, 0);
        send_frame(32'h1234_ABCD, 1'b1, 0);         // checksum off, card kept
        send_frame(32'h89AB_CDEF, 1'b0, 12);        // non-hex in checksum
    endtask

    task automatic test_miss_limits();
        logic [7:0] limits [5];
        int         n;
        limits = '{8'd0, 8'd255, 8'd254, 8'd1, 8'd7};
        foreach (limits[i]) begin
            write_miss_limit(limits[i]);
            send_frame($urandom, 1'b0, 0);
            // with 255 the count saturates and never drops
            n = (limits[i] == 8'd255) ? 260 : int'(limits[i]) + 2;
            repeat (n) send_item(REQ_TIMEOUT, 8'($urandom_range(255)));
        end
    endtask

    task automatic send_random_traffic();
        int         r;
        int         n;
        logic [31:0] id;
        r = $urandom_range(99);
        if (r < 60) begin
            n  = $urandom_range(9);
            id = (n == 0) ? 32'h0 : (n == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            send_frame(id, $urandom_range(99) < 15,
                       ($urandom_range(99) < 10) ? $urandom_range(12, 1) : 0);
        end else if (r < 70) begin
            n = $urandom_range(12, 1);
            send_item(REQ_BYTE, 8'($urandom_range(255)));
            repeat (n - 1) send_item(REQ_BYTE, hex_char(4'($urandom_range(15))));
            send_item(REQ_TIMEOUT, 8'($urandom_range(255)));
        end else if (r < 85) begin
            n = int'(miss_limit) + 2;
            if (n > 8) n = 8;
            repeat ($urandom_range(n, 1)) send_item(REQ_TIMEOUT, 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(5, 1)) send_item(REQ_BYTE, 8'($urandom_range(255)));
            if ($urandom_range(1)) send_item(REQ_TIMEOUT, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_traffic();
        int         idle_s [4];
        int         idle_m [4];
        int         start;
        bit         paused;
        idle_s = '{0, 72, 0, 38};
        idle_m = '{0, 0, 72, 38};
        for (int ph = 0; ph < 4; ph++) begin
            write_miss_limit(8'($urandom_range(4)));
            sender_idle_pct = idle_s[ph];
            stall_pct       = idle_m[ph];
            start  = items_sent;
            paused = 1'b0;
            while (items_sent - start < 210) begin
                send_random_traffic();
                if (!paused && items_sent - start >= 100) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_req_type  <= REQ_BYTE;
        s_rx_byte   <= '0;
        reset_reader();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_bad_frames();
        test_miss_limits();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
